### hdl/pars_pkg.sv
// Shared types and constants for the point-add range-sum tree.
`default_nettype none
package pars_pkg;

  localparam int POS_W = 10;
  localparam int AMT_W = 32;
  localparam int RNG_W = 11;
  localparam int SUM_W = 64;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic clr_en;
    logic add_start;
    logic add_issue;
    logic q_start;
    logic q_issue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } sts_t;

endpackage
`default_nettype wire

### hdl/pars_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
`default_nettype none
module pars_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

### hdl/pars_ctrl.sv
// Controller: clearing pass, add and query sequencing, output register valid.
`default_nettype none
module pars_ctrl #(
  parameter int LEAVES = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_kind,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire pars_pkg::sts_t sts,
  output pars_pkg::cmd_t     cmd
);

  import pars_pkg::*;

  localparam int LW  = $clog2(LEAVES);
  localparam int LVW = $clog2(LW + 2);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_ADD    = 3'd2;
  localparam logic [2:0] ST_ADD_WB = 3'd3;
  localparam logic [2:0] ST_QUERY  = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]     state, state_next;
  logic [LVW-1:0] lvl, lvl_next;
  logic           out_valid_next;
  logic           lvl_last;
  logic           accept;

  assign lvl_last = (lvl == LVW'(LW));
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid & in_ready;

  always_comb begin
    state_next     = state;
    lvl_next       = lvl;
    out_valid_next = out_valid & ~out_ready;
    cmd            = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        lvl_next = '0;
        if (accept) begin
          if (in_kind == KIND_ADD) begin
            cmd.add_start = 1'b1;
            state_next    = ST_ADD;
          end else begin
            cmd.q_start = 1'b1;
            state_next  = ST_QUERY;
          end
        end
      end
      ST_ADD: begin
        cmd.add_issue = 1'b1;
        lvl_next      = lvl + 1'b1;
        if (lvl_last) begin
          state_next = ST_ADD_WB;
        end
      end
      ST_ADD_WB: begin
        state_next = ST_IDLE;
      end
      ST_QUERY: begin
        cmd.q_issue = 1'b1;
        lvl_next    = lvl + 1'b1;
        if (lvl_last) begin
          lvl_next   = '0;
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        lvl_next = lvl + 1'b1;
        if (lvl == LVW'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      lvl       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      lvl       <= lvl_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

### hdl/pars_dp.sv
// Datapath: index saturation, node memory, path update and range accumulation.
`default_nettype none
module pars_dp #(
  parameter int LEAVES = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire pars_pkg::cmd_t                      cmd,
  output pars_pkg::sts_t                           sts,
  input  wire logic [pars_pkg::POS_W-1:0]          position,
  input  wire logic signed [pars_pkg::AMT_W-1:0]   amount,
  input  wire logic [pars_pkg::RNG_W-1:0]          range_start,
  input  wire logic [pars_pkg::RNG_W-1:0]          range_end,
  output logic signed [pars_pkg::SUM_W-1:0]        range_total
);

  import pars_pkg::*;

  localparam int LW = $clog2(LEAVES);
  localparam int AW = LW + 1;
  localparam int NW = LW + 2;
  localparam int CW = (AW > RNG_W) ? AW : RNG_W;
  localparam logic [CW-1:0] LEAVES_C = CW'(LEAVES);
  localparam logic [NW-1:0] LEAVES_N = NW'(LEAVES);

  logic [CW-1:0]    pos_ext, pos_sat, rs_ext, rs_sat, re_ext, re_sat;
  logic [AW-1:0]    leaf_idx;
  logic [NW-1:0]    lo_init, hi_init, hi_dec;
  logic             in_range;

  logic [AW-1:0]    node, wr_addr, clr_addr;
  logic             wr_pend;
  logic [NW-1:0]    lo, hi;
  logic             fa, fb;
  logic [SUM_W-1:0] delta, pair, acc;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_ra, ram_rb;
  logic [SUM_W-1:0] ram_wdata, rd_a, rd_b;

  assign pos_ext  = CW'(position);
  assign pos_sat  = (pos_ext >= LEAVES_C) ? (LEAVES_C - 1'b1) : pos_ext;
  assign leaf_idx = {1'b1, pos_sat[LW-1:0]};
  assign rs_ext   = CW'(range_start);
  assign re_ext   = CW'(range_end);
  assign rs_sat   = (rs_ext > LEAVES_C) ? LEAVES_C : rs_ext;
  assign re_sat   = (re_ext > LEAVES_C) ? LEAVES_C : re_ext;
  assign lo_init  = NW'(rs_sat[AW-1:0]) + LEAVES_N;
  assign hi_init  = NW'(re_sat[AW-1:0]) + LEAVES_N;
  assign hi_dec   = hi - 1'b1;
  assign in_range = (lo < hi);

  assign ram_we    = cmd.clr_en | wr_pend;
  assign ram_waddr = cmd.clr_en ? clr_addr : wr_addr;
  assign ram_wdata = cmd.clr_en ? '0 : (rd_a + delta);
  assign ram_ra    = cmd.q_issue ? lo[AW-1:0] : node;
  assign ram_rb    = hi_dec[AW-1:0];

  assign sts.clr_last = (clr_addr == '1);

  pars_ram #(
    .WIDTH(SUM_W),
    .DEPTH(2 * LEAVES)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr_a(ram_ra),
    .raddr_b(ram_rb),
    .rdata_a(rd_a),
    .rdata_b(rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      wr_pend  <= 1'b0;
      fa       <= 1'b0;
      fb       <= 1'b0;
      pair     <= '0;
    end else begin
      if (cmd.clr_en) begin
        clr_addr <= clr_addr + 1'b1;
      end
      wr_pend <= cmd.add_issue;
      fa      <= cmd.q_issue & in_range & lo[0];
      fb      <= cmd.q_issue & in_range & hi[0];
      pair    <= (fa ? rd_a : '0) + (fb ? rd_b : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_start) begin
      node  <= leaf_idx;
      delta <= {{(SUM_W-AMT_W){amount[AMT_W-1]}}, amount};
    end else if (cmd.add_issue) begin
      node <= node >> 1;
    end
    if (cmd.add_issue) begin
      wr_addr <= node;
    end
    if (cmd.q_start) begin
      lo <= lo_init;
      hi <= hi_init;
    end else if (cmd.q_issue) begin
      lo <= (lo + NW'(lo[0])) >> 1;
      hi <= (hi - NW'(hi[0])) >> 1;
    end
    acc <= cmd.q_start ? '0 : (acc + pair);
    if (cmd.out_load) begin
      range_total <= acc;
    end
  end

endmodule
`default_nettype wire

### hdl/point_add_range_sum_tree.sv
// Top level of the point-add range-sum tree.
//
// Input beats on s_*: tuser is the kind (add or query), tdata the fields.
// An add beat adds a sign-extended amount to one counter and gives no beat
// on m_*. A query beat gives one beat on m_* carrying the wrapping 64-bit
// sum of the counters in [range_start, range_end); an empty range gives 0.
// Out-of-range position and bounds saturate to the last counter / LEAVES.
// One item is worked at a time, walking one tree level per cycle through a
// node memory of 2*LEAVES entries with two read ports:
//   add:   after accept, s_tready stays low while a read-add-write goes
//          over each level, from the leaf up to the root.
//   query: reads one level per cycle, then a two-stage add into the
//          accumulator, and then the result goes to the output register.
// A new item is taken only once the one before it is through.
// The result sits in an output register; the next item is taken while it
// waits. A query that finishes while m_tvalid is still held waits for it.
// After reset a clearing pass zeroes the node memory, with s_tready low.
`default_nettype none
module point_add_range_sum_tree #(
  parameter int LEAVES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,  // position, amount, range_start, range_end
  input  wire logic        s_tuser,  // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata   // range_total
);

  import pars_pkg::*;

  cmd_t                     cmd;
  sts_t                     sts;
  logic [POS_W-1:0]         position;
  logic signed [AMT_W-1:0]  amount;
  logic [RNG_W-1:0]         range_start, range_end;
  logic signed [SUM_W-1:0]  range_total;

  assign position    = s_tdata[9:0];
  assign amount      = s_tdata[41:10];
  assign range_start = s_tdata[52:42];
  assign range_end   = s_tdata[63:53];
  assign m_tdata     = range_total;

  pars_ctrl #(
    .LEAVES(LEAVES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pars_dp #(
    .LEAVES(LEAVES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .position   (position),
    .amount     (amount),
    .range_start(range_start),
    .range_end  (range_end),
    .range_total(range_total)
  );

endmodule
`default_nettype wire

### hdl/pars_chk.sv
// Port-level checker for the point-add range-sum tree, bound to the top level.
`default_nettype none
module pars_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata
);

  import pars_pkg::*;

  // clearing pass follows reset: nothing taken, nothing shown
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("beat activity straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on consecutive cycles");

  a_add_no_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == KIND_ADD) && !m_tvalid |=> !m_tvalid)
    else $error("add item produced an output beat");

endmodule

bind point_add_range_sum_tree pars_chk u_pars_chk (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
`default_nettype wire

### tb/tb_point_add_range_sum_tree.sv
// Self-checking testbench for the point-add range-sum tree: directed table, random traffic.
`timescale 1ns / 1ps
module tb_point_add_range_sum_tree;
  import pars_pkg::*;

  localparam int NLEAF = 1024;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 500;
  localparam int RANDOM_ITEMS = 1400;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] pos;
    logic [AMT_W-1:0] amt;
    logic [RNG_W-1:0] lo;
    logic [RNG_W-1:0] hi;
  } item_t;

  typedef struct {
    item_t       it;
    bit          typed;
    logic [63:0] want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tuser = KIND_ADD;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  logic [SUM_W-1:0] tree_sums [0:2*NLEAF-1];
  logic [SUM_W-1:0] pending_totals [$];
  dir_row_t         dir_tab [$];
  int               errs = 0;
  int               cyc = 0;
  int               items_in = 0;
  bit               no_gap = 1'b0;

  point_add_range_sum_tree #(.LEAVES(NLEAF)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic add_to_tree(input logic [POS_W-1:0] pos, input logic [AMT_W-1:0] amt);
    int unsigned idx;
    idx = NLEAF + pos;
    while (idx >= 1) begin
      tree_sums[idx] = tree_sums[idx] + {{(SUM_W-AMT_W){amt[AMT_W-1]}}, amt};
      idx = idx >> 1;
    end
  endtask

  function automatic logic [SUM_W-1:0] range_sum(input logic [RNG_W-1:0] lo_in,
                                                 input logic [RNG_W-1:0] hi_in);
    int unsigned lo;
    int unsigned hi;
    logic [SUM_W-1:0] acc;
    lo = (lo_in > NLEAF) ? NLEAF : lo_in;
    hi = (hi_in > NLEAF) ? NLEAF : hi_in;
    acc = '0;
    if (lo >= hi) return acc;
    lo = lo + NLEAF;
    hi = hi + NLEAF;
    while (lo < hi) begin
      if (lo & 1) begin
        acc = acc + tree_sums[lo];
        lo = lo + 1;
      end
      if (hi & 1) begin
        hi = hi - 1;
        acc = acc + tree_sums[hi];
      end
      lo = lo >> 1;
      hi = hi >> 1;
    end
    return acc;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_row(input logic kind, input logic [POS_W-1:0] pos,
                         input logic [AMT_W-1:0] amt, input logic [RNG_W-1:0] lo,
                         input logic [RNG_W-1:0] hi, input bit typed,
                         input logic [63:0] want);
    dir_row_t row;
    row.it.kind = kind;
    row.it.pos = pos;
    row.it.amt = amt;
    row.it.lo = lo;
    row.it.hi = hi;
    row.typed = typed;
    row.want = want;
    dir_tab.push_back(row);
  endtask

  task automatic send_item(input item_t it, input bit typed, input logic [63:0] want);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= it.kind;
    s_tdata <= {it.hi, it.lo, it.amt, it.pos};
    do @(posedge clk); while (!s_tready);
    items_in++;
    if (it.kind == KIND_ADD) add_to_tree(it.pos, it.amt);
    else pending_totals.push_back(typed ? want : range_sum(it.lo, it.hi));
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic item_t random_item();
    item_t it;
    int r;
    it.kind = ($urandom_range(0, 99) < 50) ? KIND_QUERY : KIND_ADD;
    r = $urandom_range(0, 9);
    it.pos = (r < 3) ? POS_W'($urandom_range(0, 15)) : POS_W'($urandom);
    r = $urandom_range(0, 9);
    if (r < 5) it.amt = $urandom;
    else if (r < 8) it.amt = AMT_W'($urandom_range(0, 2000) - 1000);
    else if (r == 8) it.amt = 32'h7FFF_FFFF;
    else it.amt = 32'h8000_0000;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      it.lo = RNG_W'($urandom_range(0, NLEAF));
      it.hi = RNG_W'($urandom_range(it.lo, NLEAF));
    end else if (r < 8) begin
      it.lo = RNG_W'($urandom_range(0, 32));
      it.hi = RNG_W'($urandom_range(0, 32));
    end else begin
      it.lo = RNG_W'($urandom);
      it.hi = RNG_W'($urandom);
    end
    return it;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_totals.size() == 0) begin
        $error("unexpected result beat: range_total %0d", $signed(m_tdata));
        errs++;
      end else begin
        logic [SUM_W-1:0] want;
        want = pending_totals.pop_front();
        if (m_tdata !== want) begin
          $error("range_total mismatch: expected %0d, got %0d",
                 $signed(want), $signed(m_tdata));
          errs++;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    int run;
    int stall;
    bit held;
    held = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      run = $urandom_range(1, 30);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      if (!held && items_in >= 300) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < 2*NLEAF; i++) tree_sums[i] = '0;

    add_row(KIND_QUERY, '0, '0, 11'd0, 11'd1024, 1'b1, 64'd0);
    add_row(KIND_QUERY, '0, '0, 11'd1024, 11'd1024, 1'b1, 64'd0);
    add_row(KIND_QUERY, 10'h3FF, 32'hFFFF_FFFF, 11'd2047, 11'd2047, 1'b1, 64'd0);
    add_row(KIND_ADD, 10'd0, 32'h7FFF_FFFF, 11'd0, 11'd0, 1'b0, '0);
    add_row(KIND_ADD, 10'd1023, 32'h8000_0000, 11'd2047, 11'd2047, 1'b0, '0);
    add_row(KIND_ADD, 10'd512, 32'hFFFF_FFFF, 11'd5, 11'd3, 1'b0, '0);
    add_row(KIND_QUERY, 10'h3FF, 32'h1234_5678, 11'd0, 11'd1024, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE);
    add_row(KIND_QUERY, '0, '0, 11'd0, 11'd2047, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE);
    add_row(KIND_QUERY, '0, '0, 11'd0, 11'd1, 1'b1, 64'h0000_0000_7FFF_FFFF);
    add_row(KIND_QUERY, '0, '0, 11'd1023, 11'd2047, 1'b1, 64'hFFFF_FFFF_8000_0000);
    add_row(KIND_QUERY, '0, '0, 11'd5, 11'd3, 1'b1, 64'd0);
    add_row(KIND_QUERY, '0, '0, 11'd1500, 11'd1024, 1'b1, 64'd0);
    add_row(KIND_QUERY, '0, '0, 11'd2047, 11'd0, 1'b1, 64'd0);
    add_row(KIND_QUERY, '0, '0, 11'd1024, 11'd1500, 1'b1, 64'd0);
    add_row(KIND_ADD, 10'd511, 32'd1000, 11'd2047, 11'd1, 1'b0, '0);
    add_row(KIND_ADD, 10'd1, 32'hFFFF_FC18, 11'h555, 11'h2AA, 1'b0, '0);
    add_row(KIND_QUERY, 10'h155, 32'hAAAA_AAAA, 11'd1, 11'd1023, 1'b0, '0);
    add_row(KIND_QUERY, '0, '0, 11'd511, 11'd513, 1'b0, '0);
    add_row(KIND_QUERY, '0, '0, 11'd512, 11'd1024, 1'b0, '0);
    add_row(KIND_QUERY, '0, '0, 11'd0, 11'd512, 1'b0, '0);
    add_row(KIND_QUERY, '0, '0, 11'd1022, 11'd1024, 1'b0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) no_gap = ($urandom_range(0, 2) == 0);
      send_item(random_item(), 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    while (pending_totals.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errs == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
